@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pcs_pkg.sv @@
// Types and constants of the progressive channel selector
package pcs_pkg;

    // Field widths
    localparam int FREQ_W  = 16;
    localparam int COUNT_W = 16;
    localparam int FRAC_IN_W = 16;
    localparam int CFG_W   = 7;
    localparam int CONN_W  = 22;
    localparam int FRAC_W  = 20;
    localparam int Q_SHIFT = 12;
    localparam int WANT_W  = CONN_W + FRAC_W;

    // Saturation limits
    localparam logic [CONN_W-1:0] CONN_MAX = '1;
    localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

    // Register reset values
    localparam logic [CFG_W-1:0] MIN_RESET = 7'd0;
    localparam logic [CFG_W-1:0] MAX_RESET = 7'd64;

    // Configuration register indexes
    localparam logic CFG_MIN = 1'b0;
    localparam logic CFG_MAX = 1'b1;

    // Item kinds
    typedef enum logic [1:0] {
        REQ_HIST  = 2'd0,
        REQ_AVAIL = 2'd1,
        REQ_SCAN  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [FREQ_W-1:0]  freq;
        logic [COUNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_POP_CHECK,
        ST_POP_ACC,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_HIST_RD,
        ST_HIST_CMP,
        ST_AVAIL_RD,
        ST_AVAIL_CMP
    } state_t;

endpackage

@@ rtl/pcs_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module pcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/progressive_channel_selector_top.sv @@
// Progressive channel selector: sorted channel table with fraction-driven hand-out
//
// Holds up to TABLE_DEPTH channels in a circular RAM, sorted by descending past
// connection count. One item is worked on at a time; item_stall is high until
// the sequencer is back in idle. Most steps need one RAM read, and the RAM read
// data is registered, so the RAM port sets the timing. A history entry moves
// each entry with a smaller count up one by one and is then written, as the new
// head if every entry had a smaller count; an available channel is compared
// with each entry and appended at the tail unless a duplicate is found. Both
// are dropped when the table is full. A scan request does the target multiply,
// pops channels, makes a final stop check and emits its results (one result
// minimum); a stalled result holds the output register and the sequencer.
// A clear returns straight to idle. Results leave through an output
// register, so the next item can be taken while the last result of a request
// still waits. Table storage has no reset; only the fill count, head pointer,
// totals, state, result valid flag and configuration registers are reset.
`include "assert_macros.svh"

module progressive_channel_selector_top
    import pcs_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input items
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [1:0]           req_type,
    input  logic [FREQ_W-1:0]    channel_freq,
    input  logic [COUNT_W-1:0]   conn_count,
    input  logic [FRAC_IN_W-1:0] fraction_q12,
    // results
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [FREQ_W-1:0]    out_freq,
    output logic                 out_valid,
    output logic                 out_last,
    output logic                 more_left
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = CW + 1;

    // Sequencer and table control
    state_t                state_reg, state_next;
    logic [CW-1:0]         used_reg, used_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         start_head_reg, start_head_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [CW-1:0]         k_reg, k_next;

    // Totals
    logic [CONN_W-1:0]     total_reg, total_next;
    logic [CONN_W-1:0]     prov_reg, prov_next;
    logic [FRAC_W-1:0]     frac_reg, frac_next;
    logic [WANT_W-1:0]     want_reg, want_next;

    // Item being loaded
    logic [FREQ_W-1:0]     new_freq_reg, new_freq_next;
    logic [COUNT_W-1:0]    new_count_reg, new_count_next;

    // Configuration
    logic [CFG_W-1:0]      min_reg, min_next;
    logic [CFG_W-1:0]      max_reg, max_next;

    // Output register
    logic                  res_valid_reg, res_valid_next;
    logic [FREQ_W-1:0]     out_freq_reg, out_freq_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_last_reg, out_last_next;
    logic                  more_left_reg, more_left_next;

    // RAM port
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_addr;
    entry_t                ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                rd_entry;

    // Address generation
    logic [AW-1:0]         base_sel;
    logic [CW-1:0]         log_sel;
    logic [SW-1:0]         addr_sum;

    // Conditions and arithmetic
    logic                  accept;
    logic                  table_full;
    logic                  pop_stop;
    logic                  min_met, max_hit, target_met;
    logic                  out_free;
    logic                  emit_empty, emit_last;
    logic                  hist_move, avail_match, idx_at_end;
    logic [CFG_W-1:0]      n_ext;
    logic [CONN_W:0]       tot_sum, prov_sum;
    logic [FRAC_W:0]       frac_sum;
    logic [WANT_W-1:0]     product;
    logic [WANT_W-1:0]     prov_scaled;
    logic [AW-1:0]         head_inc;

    assign rd_entry = entry_t'(ram_rdata);

    // Table RAM, one word per entry
    pcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // Handshake
    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && (state_reg == ST_IDLE);
    assign out_free     = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign out_freq     = out_freq_reg;
    assign out_valid    = out_valid_reg;
    assign out_last     = out_last_reg;
    assign more_left    = more_left_reg;

    // Stop rules for popping
    assign table_full  = (used_reg == CW'(TABLE_DEPTH));
    assign n_ext       = CFG_W'(n_reg);
    assign min_met     = (n_ext >= min_reg);
    assign max_hit     = (n_ext >= max_reg);
    assign prov_scaled = WANT_W'({prov_reg, {Q_SHIFT{1'b0}}});
    assign target_met  = (prov_scaled >= want_reg);
    assign pop_stop    = (used_reg == '0) || (min_met && (target_met || max_hit));

    // Emit, insert and duplicate-check conditions
    assign emit_empty  = (n_reg == '0);
    assign emit_last   = emit_empty || ((k_reg + CW'(1)) == n_reg);
    assign hist_move   = (rd_entry.count < new_count_reg);
    assign avail_match = (rd_entry.freq == new_freq_reg);
    assign idx_at_end  = (idx_reg == used_reg);

    // Saturating adders and target multiply
    assign tot_sum  = {1'b0, total_reg} + (CONN_W + 1)'(conn_count);
    assign prov_sum = {1'b0, prov_reg} + (CONN_W + 1)'(rd_entry.count);
    assign frac_sum = {1'b0, frac_reg} + (FRAC_W + 1)'(fraction_q12);
    assign product  = frac_reg * total_reg;

    assign head_inc = (head_reg == AW'(TABLE_DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // Logical index to physical RAM address, wrapped around the head
    always_comb
    begin
        base_sel = head_reg;
        log_sel  = idx_reg;
        unique case (state_reg)
            ST_HIST_RD:
            begin
                log_sel = (idx_reg == '0) ? '0 : idx_reg - CW'(1);
            end
            ST_POP_CHECK:
            begin
                log_sel = '0;
            end
            ST_EMIT_RD:
            begin
                base_sel = start_head_reg;
                log_sel  = k_reg;
            end
            default:
            begin
                log_sel = idx_reg;
            end
        endcase
    end

    assign addr_sum = SW'(base_sel) + SW'(log_sel);
    assign ram_addr = (addr_sum >= SW'(TABLE_DEPTH)) ? AW'(addr_sum - SW'(TABLE_DEPTH))
                                                     : AW'(addr_sum);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_t'(req_type))
                        REQ_HIST:  state_next = table_full ? ST_IDLE : ST_HIST_RD;
                        REQ_AVAIL: state_next = table_full ? ST_IDLE : ST_AVAIL_RD;
                        REQ_SCAN:  state_next = ST_MUL;
                        REQ_CLEAR: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:
            begin
                state_next = ST_POP_CHECK;
            end
            ST_POP_CHECK:
            begin
                state_next = pop_stop ? ST_EMIT_RD : ST_POP_ACC;
            end
            ST_POP_ACC:
            begin
                state_next = ST_POP_CHECK;
            end
            ST_EMIT_RD:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            ST_HIST_RD:
            begin
                state_next = (idx_reg == '0) ? ST_IDLE : ST_HIST_CMP;
            end
            ST_HIST_CMP:
            begin
                state_next = hist_move ? ST_HIST_RD : ST_IDLE;
            end
            ST_AVAIL_RD:
            begin
                state_next = idx_at_end ? ST_IDLE : ST_AVAIL_CMP;
            end
            ST_AVAIL_CMP:
            begin
                state_next = avail_match ? ST_IDLE : ST_AVAIL_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and output register
    always_comb
    begin
        used_next       = used_reg;
        head_next       = head_reg;
        start_head_next = start_head_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        total_next      = total_reg;
        prov_next       = prov_reg;
        frac_next       = frac_reg;
        want_next       = want_reg;
        new_freq_next   = new_freq_reg;
        new_count_next  = new_count_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        out_freq_next   = out_freq_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        more_left_next  = more_left_reg;
        res_valid_next  = res_valid_reg && result_stall;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_wdata       = '{freq: new_freq_reg, count: new_count_reg};

        // Configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN: min_next = cfg_data;
                CFG_MAX: max_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    new_freq_next  = channel_freq;
                    new_count_next = conn_count;
                    unique case (req_t'(req_type))
                        REQ_HIST:
                        begin
                            if (!table_full)
                            begin
                                total_next = tot_sum[CONN_W] ? CONN_MAX : tot_sum[CONN_W-1:0];
                                idx_next   = used_reg;
                            end
                        end
                        REQ_AVAIL:
                        begin
                            new_count_next = '0;
                            idx_next       = '0;
                        end
                        REQ_SCAN:
                        begin
                            frac_next = frac_sum[FRAC_W] ? FRAC_MAX : frac_sum[FRAC_W-1:0];
                            start_head_next = head_reg;
                            n_next = '0;
                            k_next = '0;
                        end
                        REQ_CLEAR:
                        begin
                            used_next  = '0;
                            total_next = '0;
                            prov_next  = '0;
                            frac_next  = '0;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                want_next = product;
            end
            ST_POP_CHECK:
            begin
                ram_re = !pop_stop;
            end
            ST_POP_ACC:
            begin
                prov_next = prov_sum[CONN_W] ? CONN_MAX : prov_sum[CONN_W-1:0];
                n_next    = n_reg + CW'(1);
                used_next = used_reg - CW'(1);
                head_next = head_inc;
            end
            ST_EMIT_RD:
            begin
                ram_re = out_free && !emit_empty;
            end
            ST_EMIT_LD:
            begin
                res_valid_next = 1'b1;
                out_freq_next  = emit_empty ? '0 : rd_entry.freq;
                out_valid_next = !emit_empty;
                out_last_next  = emit_last;
                more_left_next = (used_reg != '0);
                k_next         = k_reg + CW'(1);
            end
            ST_HIST_RD:
            begin
                // slot zero reached: the new entry becomes the head
                if (idx_reg == '0)
                begin
                    ram_we    = 1'b1;
                    used_next = used_reg + CW'(1);
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            ST_HIST_CMP:
            begin
                ram_we = 1'b1;
                if (hist_move)
                begin
                    ram_wdata = rd_entry;
                    idx_next  = idx_reg - CW'(1);
                end
                else
                begin
                    used_next = used_reg + CW'(1);
                end
            end
            ST_AVAIL_RD:
            begin
                // no duplicate found: append at the tail
                if (idx_at_end)
                begin
                    ram_we    = 1'b1;
                    used_next = used_reg + CW'(1);
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            ST_AVAIL_CMP:
            begin
                idx_next = idx_reg + CW'(1);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            head_reg      <= '0;
            total_reg     <= '0;
            prov_reg      <= '0;
            frac_reg      <= '0;
            min_reg       <= MIN_RESET;
            max_reg       <= MAX_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            head_reg      <= head_next;
            total_reg     <= total_next;
            prov_reg      <= prov_next;
            frac_reg      <= frac_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        start_head_reg <= start_head_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        k_reg          <= k_next;
        want_reg       <= want_next;
        new_freq_reg   <= new_freq_next;
        new_count_reg  <= new_count_next;
        out_freq_reg   <= out_freq_next;
        out_valid_reg  <= out_valid_next;
        out_last_reg   <= out_last_next;
        more_left_reg  <= more_left_next;
    end

    // Checks
    `ASSERT_SAME(a_used_bound, clk, rst_n, 1'b1, used_reg <= CW'(TABLE_DEPTH), "fill count beyond table depth")
    `ASSERT_SAME(a_pop_nonempty, clk, rst_n, state_reg == ST_POP_ACC, used_reg != '0, "pop from empty table")
    `ASSERT_SAME(a_load_free, clk, rst_n, state_reg == ST_EMIT_LD, !res_valid_reg, "output register overwritten")
    `ASSERT_SAME(a_empty_last, clk, rst_n, res_valid_reg && !out_valid_reg, out_last_reg, "empty answer not last")
    `ASSERT_NEXT(a_last_idle, clk, rst_n, state_reg == ST_EMIT_LD && emit_last, state_reg == ST_IDLE, "request did not end after last result")

endmodule
